// ----- rtl/psu_pkg.sv -----
package psu_pkg;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_W  = 40;
    localparam int DIVR_W = 21;
    localparam int CNT_W  = $clog2(DIV_W + 1);

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_BEGIN   = 2'd1,
        KIND_FITNESS = 2'd2,
        KIND_DIM     = 2'd3
    } kind_t;

    localparam logic [1:0] CFG_MAX_VEL     = 2'd0;
    localparam logic [1:0] CFG_INERTIA     = 2'd1;
    localparam logic [1:0] CFG_MAX_ITER    = 2'd2;

    localparam logic signed [MUL_W-1:0] INERTIA_FLOOR = 33'sd26214;
    localparam logic [20:0] ITER_LIMIT = 21'h1FFFFF;

endpackage

// ----- rtl/psu_mul.sv -----
module psu_mul
    import psu_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/psu_div.sv -----
module psu_div
    import psu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic [DIVR_W-1:0] rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVR_W:0]   trial;

    // restoring division, one quotient bit a cycle
    assign trial = {rem_reg, quo_reg[DIV_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_reg <= DIVR_W'(trial - {1'b0, divisor});
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DIVR_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/particle_swarm_update.sv -----
// Particle swarm update engine, Q16.16.
// Input channel (in_valid / in_stall) carries one word per item: load an
// element, begin an iteration, report a particle's fitness, or update one
// coordinate. in_stall is high while an item is in work; one item at a time.
// Every item yields exactly one result word on the output channel
// (out_valid / out_stall), held in an output register.
// Dimension items run the three products through one shared multiplier;
// begin items then run the bit-serial weight divider.
// A new item can be taken while the previous result still waits; it then
// finishes only once that result has been taken.
// Config port (cfg_valid / cfg_ready, always ready): index 0 max velocity,
// 1 start inertia, 2 decay length. Write only while idle.
// Reset clears the best index, the iteration count, the weight, the
// improvement flags and the config to defaults; element and cost stores are
// undefined until loaded.
module particle_swarm_update
    import psu_pkg::*;
#(
    parameter int MAX_AGENTS = 64,
    parameter int MAX_DIMS   = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [5:0]         agent,
    input  logic [4:0]         dim,
    input  logic signed [31:0] position_in,
    input  logic signed [31:0] velocity_in,
    input  logic signed [31:0] fitness,
    input  logic [15:0]        rand_own,
    input  logic [15:0]        rand_swarm,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] new_position,
    output logic signed [31:0] new_velocity,
    output logic signed [31:0] best_fitness,
    output logic [5:0]         best_agent,
    output logic [20:0]        iteration,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int DEPTH = MAX_AGENTS * MAX_DIMS;
    localparam int AW    = $clog2(DEPTH);
    localparam int AGW   = $clog2(MAX_AGENTS);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_BEG, S_BEG_MUL, S_BEG_DIV, S_BEG_WAIT,
        S_FIT_RD, S_FIT, S_DIM_RD, S_DIM_X, S_DIM_G, S_DIM_M2,
        S_DIM_M3, S_DIM_ACC, S_DIM_WR, S_DONE
    } state_t;

    state_t state_reg;

    // config
    logic [30:0] max_vel_reg;
    logic [17:0] inertia_start_reg;
    logic [20:0] max_iter_reg;

    // block state
    logic [MAX_AGENTS-1:0] flags_reg;
    logic [5:0]            gidx_reg;
    logic [20:0]           count_reg;
    logic signed [31:0]    inertia_reg;
    logic signed [31:0]    best_reg;

    // latched item
    logic [5:0]         agent_reg;
    logic [4:0]         dim_reg;
    logic signed [31:0] pin_reg;
    logic signed [31:0] vin_reg;
    logic signed [31:0] fit_reg;
    logic [15:0]        r1_reg;
    logic [15:0]        r2_reg;

    // working registers
    logic signed [31:0] x_reg;
    logic signed [31:0] v_reg;
    logic signed [31:0] pb_reg;
    logic signed [31:0] gb_reg;
    logic signed [49:0] acc_reg;
    logic signed [31:0] res_pos_reg;
    logic signed [31:0] res_vel_reg;
    logic               neg_reg;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] out_pos_reg;
    logic signed [31:0] out_vel_reg;
    logic signed [31:0] out_best_reg;
    logic [5:0]         out_agent_reg;
    logic [20:0]        out_iter_reg;

    // stores
    logic signed [31:0] pos_mem  [DEPTH];
    logic signed [31:0] vel_mem  [DEPTH];
    logic signed [31:0] bpos_mem [DEPTH];
    logic signed [31:0] cost_mem [MAX_AGENTS];
    logic signed [31:0] pos_rd;
    logic signed [31:0] vel_rd;
    logic signed [31:0] bpos_rd;
    logic signed [31:0] cost_rd;

    logic               accept;
    logic               idx_ok;
    logic               agent_ok;
    logic [31:0]        idx_full;
    logic [31:0]        gaddr_full;
    logic [31:0]        agent_ext;
    logic [AW-1:0]      idx;
    logic [AW-1:0]      gaddr;
    logic [AW-1:0]      bpos_raddr;
    logic [AGW-1:0]     agent_ix;
    logic               imp_cur;

    logic               pos_we;
    logic               vel_we;
    logic               bpos_we;
    logic               cost_we;
    logic signed [31:0] pos_wd;
    logic signed [31:0] vel_wd;
    logic signed [31:0] bpos_wd;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [MUL_W-1:0]  diff_c;
    logic signed [MUL_W-1:0]  span_c;
    logic [20:0]              m_c;
    logic signed [MUL_W-1:0]  pbx_c;
    logic signed [MUL_W-1:0]  gbx_c;

    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;
    logic [DIV_W-1:0]   prod_mag;
    logic signed [DIV_W:0] w_c;

    logic signed [49:0] vmax_c;
    logic signed [49:0] nv_c;
    logic signed [32:0] sum_c;
    logic signed [31:0] newpos_c;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign idx_ok   = (32'(agent) < 32'(MAX_AGENTS)) && (32'(dim) < 32'(MAX_DIMS));
    assign agent_ok = (32'(agent) < 32'(MAX_AGENTS));

    assign idx_full   = 32'(agent_reg) * 32'(MAX_DIMS) + 32'(dim_reg);
    assign gaddr_full = 32'(gidx_reg) * 32'(MAX_DIMS) + 32'(dim_reg);
    assign idx        = idx_full[AW-1:0];
    assign gaddr      = gaddr_full[AW-1:0];
    assign agent_ext  = 32'(agent_reg);
    assign agent_ix   = agent_ext[AGW-1:0];
    assign imp_cur    = flags_reg[agent_ix];

    assign m_c    = (max_iter_reg == 21'd0) ? 21'd1 : max_iter_reg;
    assign diff_c = $signed({15'b0, inertia_start_reg}) - INERTIA_FLOOR;
    assign span_c = $signed({12'b0, m_c}) - $signed({12'b0, count_reg});
    assign pbx_c  = {pb_reg[31], pb_reg} - {x_reg[31], x_reg};
    assign gbx_c  = {gb_reg[31], gb_reg} - {x_reg[31], x_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_BEG_MUL:
            begin
                mul_a = diff_c;
                mul_b = span_c;
            end
            S_DIM_G:
            begin
                mul_a = {inertia_reg[31], inertia_reg};
                mul_b = {v_reg[31], v_reg};
            end
            S_DIM_M2:
            begin
                mul_a = $signed({17'b0, r1_reg});
                mul_b = pbx_c;
            end
            S_DIM_M3:
            begin
                mul_a = $signed({17'b0, r2_reg});
                mul_b = gbx_c;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    psu_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // |diff * span| stays below 2^39
    assign prod_mag  = prod[PROD_W-1] ? DIV_W'(-prod) : DIV_W'(prod);
    assign div_start = (state_reg == S_BEG_DIV);

    psu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag),
        .divisor  (m_c),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign w_c = (neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q}))
               + (DIV_W+1)'(INERTIA_FLOOR);

    // velocity clamp and position move
    assign vmax_c = $signed({19'b0, max_vel_reg});
    always_comb
    begin
        priority if (acc_reg > vmax_c)
            nv_c = vmax_c;
        else if (acc_reg < -vmax_c)
            nv_c = -vmax_c;
        else
            nv_c = acc_reg;
    end
    assign sum_c = {x_reg[31], x_reg} + {nv_c[31], nv_c[31:0]};
    always_comb
    begin
        priority if (sum_c[32] && !sum_c[31])
            newpos_c = 32'sh80000000;
        else if (!sum_c[32] && sum_c[31])
            newpos_c = 32'sh7FFFFFFF;
        else
            newpos_c = sum_c[31:0];
    end

    // store ports
    assign pos_we  = (state_reg == S_LOAD) || (state_reg == S_DIM_WR);
    assign vel_we  = pos_we;
    assign pos_wd  = (state_reg == S_LOAD) ? pin_reg : newpos_c;
    assign vel_wd  = (state_reg == S_LOAD) ? vin_reg : nv_c[31:0];
    assign bpos_we = (state_reg == S_LOAD) || ((state_reg == S_DIM_X) && imp_cur);
    assign bpos_wd = (state_reg == S_LOAD) ? pin_reg : pos_rd;
    assign cost_we = (state_reg == S_FIT) &&
                     ((count_reg <= 21'd1) || (fit_reg < cost_rd));
    assign bpos_raddr = (state_reg == S_DIM_G) ? gaddr : idx;

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[idx] <= pos_wd;
        if (vel_we)
            vel_mem[idx] <= vel_wd;
        if (bpos_we)
            bpos_mem[idx] <= bpos_wd;
        if (cost_we)
            cost_mem[agent_ix] <= fit_reg;
        pos_rd  <= pos_mem[idx];
        vel_rd  <= vel_mem[idx];
        bpos_rd <= bpos_mem[bpos_raddr];
        cost_rd <= cost_mem[agent_ix];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            max_vel_reg       <= 31'd65536;
            inertia_start_reg <= 18'd58982;
            max_iter_reg      <= 21'd1000;
            flags_reg         <= '0;
            gidx_reg          <= '0;
            count_reg         <= '0;
            inertia_reg       <= '0;
            best_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MAX_VEL:  max_vel_reg       <= cfg_data[30:0];
                    CFG_INERTIA:  inertia_start_reg <= cfg_data[17:0];
                    CFG_MAX_ITER: max_iter_reg      <= cfg_data[20:0];
                    default:      ;
                endcase
            end

            if (out_valid_reg && !out_stall && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        agent_reg   <= agent;
                        dim_reg     <= dim;
                        pin_reg     <= position_in;
                        vin_reg     <= velocity_in;
                        fit_reg     <= fitness;
                        r1_reg      <= rand_own;
                        r2_reg      <= rand_swarm;
                        res_pos_reg <= '0;
                        res_vel_reg <= '0;
                        unique case (kind_t'(kind))
                            KIND_LOAD:    state_reg <= idx_ok ? S_LOAD : S_DONE;
                            KIND_BEGIN:   state_reg <= S_BEG;
                            KIND_FITNESS: state_reg <= agent_ok ? S_FIT_RD : S_DONE;
                            KIND_DIM:     state_reg <= idx_ok ? S_DIM_RD : S_DONE;
                        endcase
                    end
                end
                S_LOAD:
                begin
                    res_pos_reg <= pin_reg;
                    res_vel_reg <= vin_reg;
                    state_reg   <= S_DONE;
                end
                S_BEG:
                begin
                    if (count_reg < ITER_LIMIT)
                        count_reg <= count_reg + 1'b1;
                    state_reg <= S_BEG_MUL;
                end
                S_BEG_MUL:
                    state_reg <= S_BEG_DIV;
                S_BEG_DIV:
                begin
                    neg_reg   <= prod[PROD_W-1];
                    state_reg <= S_BEG_WAIT;
                end
                S_BEG_WAIT:
                begin
                    if (div_done)
                    begin
                        priority if (w_c > (DIV_W+1)'(64'sh7FFFFFFF))
                            inertia_reg <= 32'sh7FFFFFFF;
                        else if (w_c < -(DIV_W+1)'(64'sh80000000))
                            inertia_reg <= 32'sh80000000;
                        else
                            inertia_reg <= w_c[31:0];
                        state_reg <= S_DONE;
                    end
                end
                S_FIT_RD:
                    state_reg <= S_FIT;
                S_FIT:
                begin
                    // best_reg mirrors the cost of the current best particle
                    priority if (count_reg <= 21'd1)
                    begin
                        flags_reg[agent_ix] <= 1'b0;
                        if (agent_reg == gidx_reg)
                            best_reg <= fit_reg;
                    end
                    else if (fit_reg < cost_rd)
                    begin
                        flags_reg[agent_ix] <= 1'b1;
                        if (fit_reg < best_reg || agent_reg == gidx_reg)
                        begin
                            gidx_reg <= agent_reg;
                            best_reg <= fit_reg;
                        end
                    end
                    else
                        flags_reg[agent_ix] <= 1'b0;
                    state_reg <= S_DONE;
                end
                S_DIM_RD:
                    state_reg <= S_DIM_X;
                S_DIM_X:
                begin
                    x_reg     <= pos_rd;
                    v_reg     <= vel_rd;
                    pb_reg    <= imp_cur ? pos_rd : bpos_rd;
                    state_reg <= S_DIM_G;
                end
                S_DIM_G:
                    state_reg <= S_DIM_M2;
                S_DIM_M2:
                begin
                    gb_reg    <= bpos_rd;
                    acc_reg   <= prod[65:16];
                    state_reg <= S_DIM_M3;
                end
                S_DIM_M3:
                begin
                    acc_reg   <= acc_reg + prod[64:15];
                    state_reg <= S_DIM_ACC;
                end
                S_DIM_ACC:
                begin
                    acc_reg   <= acc_reg + prod[64:15];
                    state_reg <= S_DIM_WR;
                end
                S_DIM_WR:
                begin
                    res_pos_reg <= newpos_c;
                    res_vel_reg <= nv_c[31:0];
                    state_reg   <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pos_reg   <= res_pos_reg;
                        out_vel_reg   <= res_vel_reg;
                        out_best_reg  <= best_reg;
                        out_agent_reg <= gidx_reg;
                        out_iter_reg  <= count_reg;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_position = out_pos_reg;
    assign new_velocity = out_vel_reg;
    assign best_fitness = out_best_reg;
    assign best_agent   = out_agent_reg;
    assign iteration    = out_iter_reg;

    a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("weight divider restarted while busy");

    a_gidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(gidx_reg) < 32'(MAX_AGENTS))
        else $error("best index out of range");

    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= $past(count_reg))
        else $error("iteration count went backwards");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> state_reg == S_DONE)
        else $error("result dropped while output word pending");

endmodule

// ----- bench/psu_checker.sv -----
module psu_checker
    import psu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [5:0]         agent,
    input  logic [4:0]         dim,
    input  logic signed [31:0] position_in,
    input  logic signed [31:0] velocity_in,
    input  logic signed [31:0] fitness,
    input  logic [15:0]        rand_own,
    input  logic [15:0]        rand_swarm,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] new_position,
    input  logic signed [31:0] new_velocity,
    input  logic signed [31:0] best_fitness,
    input  logic [5:0]         best_agent,
    input  logic [20:0]        iteration,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] cost;
        logic [5:0]         leader;
        logic [20:0]        iter;
    } swarm_word_t;

    logic signed [31:0] pos_mem [2048];
    logic signed [31:0] vel_mem [2048];
    logic signed [31:0] pbest_mem [2048];
    logic signed [31:0] cost_mem [64];
    logic               improved [64];
    logic [5:0]         leader;
    logic [20:0]        iter_cnt;
    logic signed [31:0] weight;
    logic [30:0]        vmax_reg;
    logic [17:0]        w_start_reg;
    logic [20:0]        decay_reg;

    // expected words in arrival order, ring of 16
    swarm_word_t expected_words [16];
    int          head_ptr;
    int          tail_ptr;
    int          word_count;

    assign pending = word_count;

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic swarm_word_t update_swarm(kind_t k, logic [5:0] a, logic [4:0] d,
        logic signed [31:0] p_in, logic signed [31:0] v_in, logic signed [31:0] f,
        logic [15:0] r1, logic [15:0] r2);
        swarm_word_t res;
        logic [10:0] idx;
        logic [10:0] gidx;
        longint m;
        longint x;
        longint v;
        longint pb;
        longint gb;
        longint nv;
        longint lim;
        idx = {a, d};
        gidx = {leader, d};
        res.pos = '0;
        res.vel = '0;
        unique case (k)
            KIND_LOAD:
            begin
                pos_mem[idx] = p_in;
                vel_mem[idx] = v_in;
                pbest_mem[idx] = p_in;
                res.pos = p_in;
                res.vel = v_in;
            end
            KIND_BEGIN:
            begin
                m = (decay_reg == 0) ? 1 : longint'(decay_reg);
                if (iter_cnt < ITER_LIMIT)
                    iter_cnt = iter_cnt + 21'd1;
                weight = clip32((longint'(w_start_reg) - longint'(INERTIA_FLOOR))
                    * (m - longint'(iter_cnt)) / m + longint'(INERTIA_FLOOR));
            end
            KIND_FITNESS:
            begin
                if (iter_cnt <= 1)
                begin
                    cost_mem[a] = f;
                    improved[a] = 1'b0;
                end
                else if (f < cost_mem[a])
                begin
                    cost_mem[a] = f;
                    improved[a] = 1'b1;
                    if (f < cost_mem[leader])
                        leader = a;
                end
                else
                    improved[a] = 1'b0;
            end
            default:
            begin
                if (improved[a])
                    pbest_mem[idx] = pos_mem[idx];
                x = pos_mem[idx];
                v = vel_mem[idx];
                pb = pbest_mem[idx];
                gb = pbest_mem[gidx];
                // floor shifts; >> 15 carries the factor of two
                nv = ((longint'(weight) * v) >>> 16)
                   + ((longint'(r1) * (pb - x)) >>> 15)
                   + ((longint'(r2) * (gb - x)) >>> 15);
                lim = longint'(vmax_reg);
                if (nv > lim)
                    nv = lim;
                else if (nv < -lim)
                    nv = -lim;
                vel_mem[idx] = nv[31:0];
                pos_mem[idx] = clip32(x + nv);
                res.pos = pos_mem[idx];
                res.vel = nv[31:0];
            end
        endcase
        res.cost = cost_mem[leader];
        res.leader = leader;
        res.iter = iter_cnt;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        swarm_word_t got;
        swarm_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 64; i++)
                improved[i] = 1'b0;
            leader = '0;
            iter_cnt = '0;
            weight = '0;
            vmax_reg = 31'd65536;
            w_start_reg = 18'd58982;
            decay_reg = 21'd1000;
            fail_count = 0;
            head_ptr = 0;
            tail_ptr = 0;
            word_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.pos = new_position;
                got.vel = new_velocity;
                got.cost = best_fitness;
                got.leader = best_agent;
                got.iter = iteration;
                if (word_count == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word: pos %0d vel %0d",
                            got.pos, got.vel);
                end
                else
                begin
                    want = expected_words[head_ptr];
                    head_ptr = (head_ptr + 1) % 16;
                    word_count--;
                    if (got.pos !== want.pos || got.vel !== want.vel
                        || got.cost !== want.cost || got.leader !== want.leader
                        || got.iter !== want.iter)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: exp pos %0d vel %0d cost %0d agent %0d",
                                " it %0d, got pos %0d vel %0d cost %0d agent %0d it %0d"},
                                want.pos, want.vel, want.cost, want.leader, want.iter,
                                got.pos, got.vel, got.cost, got.leader, got.iter);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_words[tail_ptr] = update_swarm(kind_t'(kind), agent, dim,
                    position_in, velocity_in, fitness, rand_own, rand_swarm);
                tail_ptr = (tail_ptr + 1) % 16;
                word_count++;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MAX_VEL:  vmax_reg = cfg_data[30:0];
                    CFG_INERTIA:  w_start_reg = cfg_data[17:0];
                    CFG_MAX_ITER: decay_reg = cfg_data[20:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- bench/tb_top.sv -----
module tb_top
    import psu_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         kind;
    logic [5:0]         agent;
    logic [4:0]         dim;
    logic signed [31:0] position_in;
    logic signed [31:0] velocity_in;
    logic signed [31:0] fitness;
    logic [15:0]        rand_own;
    logic [15:0]        rand_swarm;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] new_position;
    logic signed [31:0] new_velocity;
    logic signed [31:0] best_fitness;
    logic [5:0]         best_agent;
    logic [20:0]        iteration;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    int                 fail_count;
    int                 pending;

    // particles and coordinates that are always loaded; bit patterns cover every field bit
    int                 swarm_ids [4] = '{0, 21, 42, 63};
    int                 coord_ids [4] = '{0, 10, 21, 31};
    int                 sent;
    bit                 no_idle;
    bit                 hold_req;
    bit                 hold_seen;

    particle_swarm_update dut (.*);

    psu_checker u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 32'h3fffff)) - 32'sh1fffff;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_cost();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 2000000)) - 32'sd1000000;
        endcase
    endfunction

    task automatic send_word(kind_t k, int a, int d, logic signed [31:0] p,
        logic signed [31:0] v, logic signed [31:0] f, logic [31:0] r1, logic [31:0] r2);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        kind <= k;
        agent <= 6'(a);
        dim <= 5'(d);
        position_in <= p;
        velocity_in <= v;
        fitness <= f;
        rand_own <= r1[15:0];
        rand_swarm <= r2[15:0];
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (60) @(posedge clk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_iteration();
        send_word(KIND_BEGIN, $urandom_range(0, 63), $urandom_range(0, 31),
            $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        foreach (swarm_ids[i])
        begin
            send_word(KIND_FITNESS, swarm_ids[i], $urandom_range(0, 31), $urandom(),
                $urandom(), pick_cost(), $urandom(), $urandom());
            foreach (coord_ids[j])
                send_word(KIND_DIM, swarm_ids[i], coord_ids[j], $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom());
        end
    endtask

    task automatic change_settings();
        case ($urandom_range(0, 5))
            0: write_reg(CFG_MAX_VEL, $urandom_range(0, 1) ? 32'hffffffff : 32'h0);
            1: write_reg(CFG_MAX_VEL, $urandom_range(1000, 8000000));
            2: write_reg(CFG_INERTIA, $urandom_range(0, 1) ? 32'd131072 : 32'd0);
            3: write_reg(CFG_INERTIA, $urandom_range(0, 131072));
            4: write_reg(CFG_MAX_ITER, $urandom_range(0, 2) == 0 ? 32'd1048576
                : $urandom_range(0, 1));
            default: write_reg(CFG_MAX_ITER, $urandom_range(2, 200));
        endcase
    endtask

    // result side: random stalls per word, plus one long hold-off on request
    initial
    begin
        int n;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_req != hold_seen)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_seen = hold_req;
            end
            n = no_idle ? 0 : $urandom_range(0, 11);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        sent = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        kind <= KIND_LOAD;
        agent <= '0;
        dim <= '0;
        position_in <= '0;
        velocity_in <= '0;
        fitness <= '0;
        rand_own <= '0;
        rand_swarm <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MAX_VEL;
        cfg_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: costs recorded first so the best cost is always defined
        foreach (swarm_ids[i])
            send_word(KIND_FITNESS, swarm_ids[i], 0, 0, 0,
                i == 0 ? 32'sh7fffffff : 32'sh80000000 + i, 32'h0, 32'h0);
        foreach (swarm_ids[i])
            foreach (coord_ids[j])
                send_word(KIND_LOAD, swarm_ids[i], coord_ids[j],
                    j == 0 ? 32'sh7fffffff : (j == 1 ? 32'sh80000000 : pick_coord()),
                    j == 2 ? 32'sh7fffffff : (j == 3 ? 32'sh80000000 : pick_coord()),
                    0, 32'hffff, 32'hffff);
        // dimension update with zero weight
        send_word(KIND_DIM, 63, 31, 0, 0, 0, 32'hffff, 32'hffff);
        send_word(KIND_BEGIN, 0, 0, 0, 0, 0, 0, 0);
        send_word(KIND_FITNESS, 21, 0, 0, 0, 32'sh80000000, 0, 0);
        send_word(KIND_DIM, 21, 10, 0, 0, 0, 32'hffff, 32'h0);
        write_reg(CFG_MAX_VEL, 32'h7fffffff);
        write_reg(CFG_INERTIA, 32'd131072);
        write_reg(CFG_MAX_ITER, 32'd0);
        run_iteration();
        run_iteration();
        write_reg(CFG_MAX_ITER, 32'd1048576);
        write_reg(CFG_MAX_VEL, 32'd0);
        run_iteration();

        while (sent < 1220)
        begin
            no_idle = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 19))
                0, 1:
                    repeat ($urandom_range(1, 8))
                        send_word(KIND_LOAD, $urandom_range(0, 63), $urandom_range(0, 31),
                            pick_coord(), pick_coord(), $urandom(), $urandom(), $urandom());
                2:
                    repeat ($urandom_range(1, 4))
                        send_word(KIND_LOAD, swarm_ids[$urandom_range(0, 3)],
                            coord_ids[$urandom_range(0, 3)], pick_coord(), pick_coord(),
                            $urandom(), $urandom(), $urandom());
                3:
                    send_word(KIND_FITNESS, swarm_ids[$urandom_range(0, 3)],
                        $urandom_range(0, 31), $urandom(), $urandom(), pick_cost(),
                        $urandom(), $urandom());
                4:
                    send_word(KIND_DIM, swarm_ids[$urandom_range(0, 3)],
                        coord_ids[$urandom_range(0, 3)], $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom());
                5:
                    change_settings();
                6:
                begin
                    hold_req = ~hold_req;
                    repeat (10)
                        send_word(KIND_DIM, swarm_ids[$urandom_range(0, 3)],
                            coord_ids[$urandom_range(0, 3)], $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom());
                    in_valid <= 1'b0;
                    @(posedge clk);
                    wait (pending == 0);
                    @(posedge clk);
                end
                default:
                    run_iteration();
            endcase
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- particle_swarm_update.f -----
rtl/psu_pkg.sv
rtl/psu_mul.sv
rtl/psu_div.sv
rtl/particle_swarm_update.sv
bench/psu_checker.sv
bench/tb_top.sv
